// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the canvas RTL.
// Included by rect_raster_canvas.sv; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cons must hold in the same cycle as ante
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// cons must hold in the cycle after ante
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/rrc_pkg.sv
// Package for the rectangle raster canvas: codes, widths and defaults.
// Used by rect_raster_canvas.sv; depends on nothing.
package rrc_pkg;

  localparam int unsigned MAX_SIDE_DEF = 512;
  localparam int unsigned ONE_UNIT     = 256;
  localparam int unsigned DW           = 27;

  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_DRAW  = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam logic [1:0] REG_CANVAS_WIDTH    = 2'd0;
  localparam logic [1:0] REG_CANVAS_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_BACKGROUND_CHAR = 2'd2;

  localparam logic [9:0] CANVAS_SIDE_RST = 10'd1;
  localparam logic [7:0] BACKGROUND_RST  = 8'd32;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SETUP = 5'b00010,
    S_SWEEP = 5'b00100,
    S_READ  = 5'b01000,
    S_FIN   = 5'b10000
  } state_e;

endpackage

// File: hw/rtl/rect_raster_canvas.sv
// Character canvas with clear, rectangle draw and pixel read commands.
// Depends on rrc_pkg and assert_macros.svh.
//
// Usage:
//   Commands enter on the in channel (valid/ready); one result per command
//   leaves on the out channel (valid/ready) as status and pixel_char.
//   Registers canvas width, height and background byte are to be written through
//   cfg_we_i/cfg_index_i/cfg_data_i while the block is idle; it does not enforce this.
//   A clear or draw walks the active canvas one pixel per cycle through the
//   single write port of the canvas memory. A zero-size draw and the unused
//   action skip the walk; a read passes through one memory read state first.
//   The block takes one command at a time; in_ready_o is high only when idle.
//   The result sits in an output register, so the next command may start
//   while the receiver stalls; a command finishing while the previous result
//   is still held waits for it to be taken.
//   Reset sets width and height to 1 and the background byte to 32. The
//   memory is not cleared; read only pixels written by a clear or a draw.
`include "assert_macros.svh"

module rect_raster_canvas import rrc_pkg::*; #(
  parameter int unsigned MAX_SIDE = MAX_SIDE_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [9:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic        filled_i,
  input  logic [23:0] rect_left_i,
  input  logic [23:0] rect_top_i,
  input  logic [22:0] rect_width_i,
  input  logic [22:0] rect_height_i,
  input  logic [7:0]  paint_char_i,
  input  logic [8:0]  read_col_i,
  input  logic [8:0]  read_row_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        status_o,
  output logic [7:0]  pixel_char_o
);

  localparam int unsigned SW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int unsigned AW    = 2 * SW;
  localparam int unsigned CMP_W = (SW + 1 > 10) ? SW + 1 : 10;

  state_e state_q, state_d;

  logic [9:0] cfg_width_q, cfg_height_q;
  logic [7:0] bg_q;

  logic [1:0]    act_q;
  logic          fill_q, zero_q, inrange_q;
  logic [7:0]    paint_q;
  logic [SW-1:0] rd_col_q, rd_row_q;
  logic [SW-1:0] col_last_q, row_last_q;
  logic [SW-1:0] col_q, row_q;

  logic signed [DW-1:0] nleft_q, right_q, dx_l_q, dx_r_q, dy_t_q, dy_b_q;
  logic signed [DW-1:0] left_ext, top_ext, wid_ext, hei_ext;

  logic [7:0] mem [2**AW];
  logic [7:0] rdata_q;

  logic       out_valid_q, status_q;
  logic [7:0] pixel_q;

  logic [CMP_W-1:0] cols, rows, rcol_ext, rrow_ext;
  logic             accept, covered, near_edge, mem_we, col_end, row_end, out_load;
  logic [7:0]       wdata;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cols = CMP_W'(cfg_width_q);
    if (cols == '0) begin
      cols = CMP_W'(1);
    end else if (cols > CMP_W'(MAX_SIDE)) begin
      cols = CMP_W'(MAX_SIDE);
    end
    rows = CMP_W'(cfg_height_q);
    if (rows == '0) begin
      rows = CMP_W'(1);
    end else if (rows > CMP_W'(MAX_SIDE)) begin
      rows = CMP_W'(MAX_SIDE);
    end
  end

  assign rcol_ext = CMP_W'(read_col_i);
  assign rrow_ext = CMP_W'(read_row_i);

  assign left_ext = DW'($signed(rect_left_i));
  assign top_ext  = DW'($signed(rect_top_i));
  assign wid_ext  = DW'(rect_width_i);
  assign hei_ext  = DW'(rect_height_i);

  assign covered   = !dx_l_q[DW-1] && !dx_r_q[DW-1] && !dy_t_q[DW-1] && !dy_b_q[DW-1];
  assign near_edge = (dx_l_q[DW-1:8] == '0) || (dx_r_q[DW-1:8] == '0) ||
                     (dy_t_q[DW-1:8] == '0) || (dy_b_q[DW-1:8] == '0);
  assign mem_we    = (state_q == S_SWEEP) &&
                     ((act_q == ACT_CLEAR) || (covered && (near_edge || fill_q)));
  assign wdata     = (act_q == ACT_CLEAR) ? bg_q : paint_q;
  assign col_end   = (col_q == col_last_q);
  assign row_end   = (row_q == row_last_q);
  assign out_load  = (state_q == S_FIN) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (action_i)
            ACT_CLEAR: state_d = S_SETUP;
            ACT_DRAW:  state_d = ((rect_width_i == '0) || (rect_height_i == '0)) ?
                                 S_FIN : S_SETUP;
            ACT_READ:  state_d = S_READ;
            default:   state_d = S_FIN;
          endcase
        end
      end
      S_SETUP: state_d = S_SWEEP;
      S_SWEEP: begin
        if (col_end && row_end) begin
          state_d = S_FIN;
        end
      end
      S_READ:  state_d = S_FIN;
      S_FIN: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cfg_width_q  <= CANVAS_SIDE_RST;
      cfg_height_q <= CANVAS_SIDE_RST;
      bg_q         <= BACKGROUND_RST;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_CANVAS_WIDTH:    cfg_width_q  <= cfg_data_i;
          REG_CANVAS_HEIGHT:   cfg_height_q <= cfg_data_i;
          REG_BACKGROUND_CHAR: bg_q         <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q      <= action_i;
      fill_q     <= filled_i;
      paint_q    <= paint_char_i;
      zero_q     <= (rect_width_i == '0) || (rect_height_i == '0);
      inrange_q  <= (rcol_ext < cols) && (rrow_ext < rows);
      rd_col_q   <= rcol_ext[SW-1:0];
      rd_row_q   <= rrow_ext[SW-1:0];
      col_last_q <= SW'(cols - CMP_W'(1));
      row_last_q <= SW'(rows - CMP_W'(1));
      nleft_q    <= -left_ext;
      right_q    <= left_ext + wid_ext;
      dy_t_q     <= -top_ext;
      dy_b_q     <= top_ext + hei_ext;
    end
    case (state_q)
      S_SETUP: begin
        col_q  <= '0;
        row_q  <= '0;
        dx_l_q <= nleft_q;
        dx_r_q <= right_q;
      end
      S_SWEEP: begin
        if (col_end) begin
          col_q  <= '0;
          dx_l_q <= nleft_q;
          dx_r_q <= right_q;
          row_q  <= row_q + SW'(1);
          dy_t_q <= dy_t_q + DW'(ONE_UNIT);
          dy_b_q <= dy_b_q - DW'(ONE_UNIT);
        end else begin
          col_q  <= col_q + SW'(1);
          dx_l_q <= dx_l_q + DW'(ONE_UNIT);
          dx_r_q <= dx_r_q - DW'(ONE_UNIT);
        end
      end
      default: ;
    endcase
    if (out_load) begin
      status_q <= (act_q == ACT_DRAW) && zero_q;
      pixel_q  <= ((act_q == ACT_READ) && inrange_q) ? rdata_q : 8'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[{row_q, col_q}] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_READ) begin
      rdata_q <= mem[{rd_row_q, rd_col_q}];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign pixel_char_o = pixel_q;

  `ASSERT_IMPLIES(a_we_in_sweep, clk_i, rst_ni, mem_we, state_q == S_SWEEP,
                  "canvas write outside sweep")
  `ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, accept, state_q != S_IDLE,
               "accepted transaction left block idle")
  `ASSERT_NEXT(a_fin_loads, clk_i, rst_ni, out_load, out_valid_q && state_q == S_IDLE,
               "finished transaction not presented")
  `ASSERT_IMPLIES(a_reject_no_pixel, clk_i, rst_ni, out_valid_o && status_o,
                  pixel_char_o == 8'd0, "rejected draw carries pixel data")

endmodule
